// File: src/bgrs_pkg.sv
package bgrs_pkg;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 20;
  localparam int CMD_W    = 2;
  localparam int CFG_W    = 3;

  localparam int BLOCK_SIZE_DEFAULT      = 64;
  localparam int MAX_RAMP_BLOCKS_DEFAULT = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 3'd2;

  localparam logic signed [GAIN_W-1:0] GAIN_UNITY = 20'sd65536;

  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FORCE  = 2'd2;

  // quotient of the ramp fraction is as wide as a gain, one bit per step
  localparam int DIV_STEPS = GAIN_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic accept;
    logic mul;
    logic div_step;
    logic gain;
    logic scale;
    logic out_load;
  } bgrs_cmd_t;

  typedef struct packed {
    logic is_sample;
    logic ramp_now;
  } bgrs_stat_t;

endpackage

// File: src/bgrs_ctrl.sv
module bgrs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bgrs_pkg::bgrs_stat_t stat,
  output bgrs_pkg::bgrs_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_GAIN,
    S_SCALE,
    S_OUT
  } state_t;

  state_t state;
  logic [bgrs_pkg::DIV_CNT_W-1:0] cnt;

  localparam logic [bgrs_pkg::DIV_CNT_W-1:0] CNT_LAST =
    bgrs_pkg::DIV_CNT_W'(bgrs_pkg::DIV_STEPS - 1);

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.accept   = in_valid && in_ready;
    cmd.mul      = (state == S_MUL);
    cmd.div_step = (state == S_DIV);
    cmd.gain     = (state == S_GAIN);
    cmd.scale    = (state == S_SCALE);
    cmd.out_load = (state == S_OUT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.accept && stat.is_sample) begin
            state <= stat.ramp_now ? S_MUL : S_GAIN;
          end
        end
        S_MUL: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == CNT_LAST) begin
            state <= S_GAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_GAIN:  state <= S_SCALE;
        S_SCALE: state <= S_OUT;
        S_OUT: begin
          if (cmd.out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cnt <= CNT_LAST))
    else $error("divider step count out of range");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && stat.is_sample) |=> (state != S_IDLE))
    else $error("sample word accepted but controller stayed idle");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_OUT))
    else $error("output word raised outside output state");

  a_mul_to_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |=> (state == S_DIV && cnt == '0))
    else $error("divider not started after ramp multiply");

endmodule

// File: src/bgrs_dp.sv
module bgrs_dp #(
  parameter int BLOCK_SIZE      = bgrs_pkg::BLOCK_SIZE_DEFAULT,
  parameter int MAX_RAMP_BLOCKS = bgrs_pkg::MAX_RAMP_BLOCKS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bgrs_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic [bgrs_pkg::CMD_W-1:0]           command,
  input  logic signed [bgrs_pkg::SAMPLE_W-1:0] sample_in,
  input  logic signed [bgrs_pkg::GAIN_W-1:0]   gain_value,
  output logic signed [bgrs_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                 ramping,
  input  bgrs_pkg::bgrs_cmd_t                  cmd,
  output bgrs_pkg::bgrs_stat_t                 stat
);

  localparam int GW      = bgrs_pkg::GAIN_W;
  localparam int SW      = bgrs_pkg::SAMPLE_W;
  localparam int MAX_LEN = BLOCK_SIZE * MAX_RAMP_BLOCKS;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int POS_W   = $clog2(MAX_LEN);
  localparam int BLK_W   = $clog2(BLOCK_SIZE);
  localparam int PROD_W  = GW + POS_W;
  localparam int P_W     = SW + GW;

  localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(BLOCK_SIZE - 1);
  localparam logic signed [P_W-1:0] ROUND_HALF = P_W'(32768);
  localparam logic signed [P_W-1:0] OUT_MAX    = P_W'(8388607);
  localparam logic signed [P_W-1:0] OUT_MIN    = -P_W'(8388608);

  // architectural state
  logic [bgrs_pkg::CFG_W-1:0] ramp_blocks_log2;
  logic [BLK_W-1:0]           block_index;
  logic [POS_W-1:0]           ramp_position;
  logic signed [GW-1:0]       current_gain;
  logic signed [GW-1:0]       latched_target;
  logic signed [GW-1:0]       pending_target;
  logic                       ramp_active;

  // per-sample working registers
  logic signed [SW-1:0] w_sample;
  logic signed [GW-1:0] w_cur;
  logic [GW-1:0]        w_mag;
  logic                 w_neg;
  logic [POS_W-1:0]     w_pos;
  logic [LEN_W-1:0]     w_len;
  logic                 w_ramp;
  logic [LEN_W-1:0]     rem;
  logic [GW-1:0]        dlo;
  logic [GW-1:0]        quo;
  logic signed [GW-1:0] g;
  logic signed [P_W-1:0] p;

  // ramp decision at accept
  logic [7:0]           blocks_raw;
  logic [7:0]           blocks_sat;
  logic [LEN_W-1:0]     len;
  logic                 start;
  logic signed [GW-1:0] lat1;
  logic                 act1;
  logic [LEN_W-1:0]     pos1;
  logic                 end1;
  logic signed [GW-1:0] cur2;
  logic                 act2;
  logic [LEN_W-1:0]     pos2;
  logic [LEN_W-1:0]     pos3;
  logic                 end2;
  logic signed [GW:0]   diff;

  // datapath arithmetic
  logic [PROD_W-1:0]    prod;
  logic [LEN_W:0]       trial;
  logic                 ge;
  logic signed [GW:0]   q_s;
  logic signed [GW:0]   gsum;
  logic signed [P_W-1:0] rnd;
  logic signed [P_W-1:0] r;
  logic signed [SW-1:0] sat;

  always_comb begin
    blocks_raw = 8'd1 << ramp_blocks_log2;
    blocks_sat = (blocks_raw > 8'(MAX_RAMP_BLOCKS)) ? 8'(MAX_RAMP_BLOCKS) : blocks_raw;
    len        = LEN_W'(blocks_sat * BLOCK_SIZE);

    start = (block_index == '0) && !ramp_active && (current_gain != pending_target);
    lat1  = start ? pending_target : latched_target;
    act1  = ramp_active || start;
    pos1  = start ? '0 : LEN_W'(ramp_position);
    // length may have shrunk under a running ramp
    end1  = act1 && (pos1 >= len);
    cur2  = end1 ? lat1 : current_gain;
    act2  = act1 && !end1;
    pos2  = end1 ? '0 : pos1;
    pos3  = pos2 + 1'b1;
    end2  = act2 && (pos3 >= len);
    diff  = (GW+1)'(lat1) - (GW+1)'(cur2);

    stat.is_sample = (command == bgrs_pkg::CMD_SAMPLE);
    stat.ramp_now  = act2;
  end

  always_comb begin
    prod  = w_mag * w_pos;
    trial = {rem, dlo[GW-1]};
    ge    = (trial >= {1'b0, w_len});
    q_s   = {1'b0, quo};
    gsum  = (GW+1)'(w_cur) + (w_neg ? -q_s : q_s);
    rnd   = p + ROUND_HALF;
    r     = rnd >>> 16;
    if (r > OUT_MAX) begin
      sat = SW'(OUT_MAX);
    end else if (r < OUT_MIN) begin
      sat = SW'(OUT_MIN);
    end else begin
      sat = SW'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_blocks_log2 <= bgrs_pkg::CFG_RESET;
    end else if (cfg_we) begin
      ramp_blocks_log2 <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_index    <= '0;
      ramp_position  <= '0;
      current_gain   <= bgrs_pkg::GAIN_UNITY;
      latched_target <= bgrs_pkg::GAIN_UNITY;
      pending_target <= bgrs_pkg::GAIN_UNITY;
      ramp_active    <= 1'b0;
    end else if (cmd.accept) begin
      case (command)
        bgrs_pkg::CMD_SET: begin
          pending_target <= gain_value;
        end
        bgrs_pkg::CMD_FORCE: begin
          pending_target <= gain_value;
          latched_target <= gain_value;
          current_gain   <= gain_value;
          ramp_active    <= 1'b0;
          ramp_position  <= '0;
        end
        bgrs_pkg::CMD_SAMPLE: begin
          latched_target <= lat1;
          current_gain   <= end2 ? lat1 : cur2;
          ramp_active    <= act2 && !end2;
          if (act2) begin
            ramp_position <= end2 ? '0 : POS_W'(pos3);
          end else begin
            ramp_position <= POS_W'(pos2);
          end
          block_index <= (block_index == BLK_LAST) ? '0 : block_index + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && stat.is_sample) begin
      w_sample <= sample_in;
      w_cur    <= cur2;
      w_neg    <= diff[GW];
      w_mag    <= GW'(diff[GW] ? -diff : diff);
      w_pos    <= POS_W'(pos2);
      w_len    <= len;
      w_ramp   <= act2;
    end
    // magnitude of diff*pos over len, restoring, one quotient bit a step;
    // the top bits already sit below len since the quotient fits a gain
    if (cmd.mul) begin
      rem <= LEN_W'(prod[PROD_W-1:GW]);
      dlo <= prod[GW-1:0];
      quo <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? LEN_W'(trial - {1'b0, w_len}) : LEN_W'(trial);
      dlo <= {dlo[GW-2:0], 1'b0};
      quo <= {quo[GW-2:0], ge};
    end
    if (cmd.gain) begin
      g <= w_ramp ? GW'(gsum) : w_cur;
    end
    if (cmd.scale) begin
      p <= P_W'(w_sample) * P_W'(g);
    end
    if (cmd.out_load) begin
      sample_out <= sat;
      ramping    <= w_ramp;
    end
  end

endmodule

// File: src/block_gain_ramp_smoother_core.sv
// Gain stage with click-free linear ramps for a 24-bit sample stream. Each
// word carries a command: a sample, a new pending target gain, or a gain
// forced at once; gains are signed Q3.16. Set and force words give no
// result. A steady-gain sample passes the gain, scale and output states; a
// sample inside a ramp first passes a multiply state for the product and
// then the restoring divider that forms (target - start) * position / length
// one quotient bit per cycle. Results sit in an output register, so the
// next word is taken while a result waits. Ramp length is 2^ramp_blocks_log2
// blocks, capped at MAX_RAMP_BLOCKS, written via cfg_we.
module block_gain_ramp_smoother_core #(
  parameter int BLOCK_SIZE      = bgrs_pkg::BLOCK_SIZE_DEFAULT,
  parameter int MAX_RAMP_BLOCKS = bgrs_pkg::MAX_RAMP_BLOCKS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bgrs_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bgrs_pkg::CMD_W-1:0]           command,
  input  logic signed [bgrs_pkg::SAMPLE_W-1:0] sample_in,
  input  logic signed [bgrs_pkg::GAIN_W-1:0]   gain_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bgrs_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                 ramping
);

  bgrs_pkg::bgrs_cmd_t  cmd;
  bgrs_pkg::bgrs_stat_t stat;

  bgrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bgrs_dp #(
    .BLOCK_SIZE      (BLOCK_SIZE),
    .MAX_RAMP_BLOCKS (MAX_RAMP_BLOCKS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .command    (command),
    .sample_in  (sample_in),
    .gain_value (gain_value),
    .sample_out (sample_out),
    .ramping    (ramping),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule
